[rtl/core/kup_pkg.sv]
package kup_pkg;

    typedef logic [1023:0] blk_t;

    typedef struct packed {
        logic       q_mode;
        logic [3:0] rnd;
    } round_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PAD,
        ST_FILL,
        ST_INIT,
        ST_OINIT,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } fsm_t;

    localparam logic [63:0] AddConst  = 64'h00F0F0F0F0F0F0F3;
    localparam logic [7:0]  PadByte   = 8'h80;
    localparam logic [6:0]  LenAt     = 7'd116;
    localparam logic [3:0]  LastRound = 4'd13;
    localparam logic [6:0]  MaxDigest = 7'd64;
    localparam logic [6:0]  LastByte  = 7'd127;

    localparam logic [3:0] MDS_ROW [8] = '{4'd1, 4'd1, 4'd5, 4'd1, 4'd8, 4'd6, 4'd7, 4'd4};

    localparam logic [7:0] KSB [4][256] = '{
        '{
        8'ha8,8'h43,8'h5f,8'h06,8'h6b,8'h75,8'h6c,8'h59,8'h71,8'hdf,8'h87,8'h95,8'h17,8'hf0,8'hd8,8'h09,
        8'h6d,8'hf3,8'h1d,8'hcb,8'hc9,8'h4d,8'h2c,8'haf,8'h79,8'he0,8'h97,8'hfd,8'h6f,8'h4b,8'h45,8'h39,
        8'h3e,8'hdd,8'ha3,8'h4f,8'hb4,8'hb6,8'h9a,8'h0e,8'h1f,8'hbf,8'h15,8'he1,8'h49,8'hd2,8'h93,8'hc6,
        8'h92,8'h72,8'h9e,8'h61,8'hd1,8'h63,8'hfa,8'hee,8'hf4,8'h19,8'hd5,8'had,8'h58,8'ha4,8'hbb,8'ha1,
        8'hdc,8'hf2,8'h83,8'h37,8'h42,8'he4,8'h7a,8'h32,8'h9c,8'hcc,8'hab,8'h4a,8'h8f,8'h6e,8'h04,8'h27,
        8'h2e,8'he7,8'he2,8'h5a,8'h96,8'h16,8'h23,8'h2b,8'hc2,8'h65,8'h66,8'h0f,8'hbc,8'ha9,8'h47,8'h41,
        8'h34,8'h48,8'hfc,8'hb7,8'h6a,8'h88,8'ha5,8'h53,8'h86,8'hf9,8'h5b,8'hdb,8'h38,8'h7b,8'hc3,8'h1e,
        8'h22,8'h33,8'h24,8'h28,8'h36,8'hc7,8'hb2,8'h3b,8'h8e,8'h77,8'hba,8'hf5,8'h14,8'h9f,8'h08,8'h55,
        8'h9b,8'h4c,8'hfe,8'h60,8'h5c,8'hda,8'h18,8'h46,8'hcd,8'h7d,8'h21,8'hb0,8'h3f,8'h1b,8'h89,8'hff,
        8'heb,8'h84,8'h69,8'h3a,8'h9d,8'hd7,8'hd3,8'h70,8'h67,8'h40,8'hb5,8'hde,8'h5d,8'h30,8'h91,8'hb1,
        8'h78,8'h11,8'h01,8'he5,8'h00,8'h68,8'h98,8'ha0,8'hc5,8'h02,8'ha6,8'h74,8'h2d,8'h0b,8'ha2,8'h76,
        8'hb3,8'hbe,8'hce,8'hbd,8'hae,8'he9,8'h8a,8'h31,8'h1c,8'hec,8'hf1,8'h99,8'h94,8'haa,8'hf6,8'h26,
        8'h2f,8'hef,8'he8,8'h8c,8'h35,8'h03,8'hd4,8'h7f,8'hfb,8'h05,8'hc1,8'h5e,8'h90,8'h20,8'h3d,8'h82,
        8'hf7,8'hea,8'h0a,8'h0d,8'h7e,8'hf8,8'h50,8'h1a,8'hc4,8'h07,8'h57,8'hb8,8'h3c,8'h62,8'he3,8'hc8,
        8'hac,8'h52,8'h64,8'h10,8'hd0,8'hd9,8'h13,8'h0c,8'h12,8'h29,8'h51,8'hb9,8'hcf,8'hd6,8'h73,8'h8d,
        8'h81,8'h54,8'hc0,8'hed,8'h4e,8'h44,8'ha7,8'h2a,8'h85,8'h25,8'he6,8'hca,8'h7c,8'h8b,8'h56,8'h80
        },
        '{
        8'hce,8'hbb,8'heb,8'h92,8'hea,8'hcb,8'h13,8'hc1,8'he9,8'h3a,8'hd6,8'hb2,8'hd2,8'h90,8'h17,8'hf8,
        8'h42,8'h15,8'h56,8'hb4,8'h65,8'h1c,8'h88,8'h43,8'hc5,8'h5c,8'h36,8'hba,8'hf5,8'h57,8'h67,8'h8d,
        8'h31,8'hf6,8'h64,8'h58,8'h9e,8'hf4,8'h22,8'haa,8'h75,8'h0f,8'h02,8'hb1,8'hdf,8'h6d,8'h73,8'h4d,
        8'h7c,8'h26,8'h2e,8'hf7,8'h08,8'h5d,8'h44,8'h3e,8'h9f,8'h14,8'hc8,8'hae,8'h54,8'h10,8'hd8,8'hbc,
        8'h1a,8'h6b,8'h69,8'hf3,8'hbd,8'h33,8'hab,8'hfa,8'hd1,8'h9b,8'h68,8'h4e,8'h16,8'h95,8'h91,8'hee,
        8'h4c,8'h63,8'h8e,8'h5b,8'hcc,8'h3c,8'h19,8'ha1,8'h81,8'h49,8'h7b,8'hd9,8'h6f,8'h37,8'h60,8'hca,
        8'he7,8'h2b,8'h48,8'hfd,8'h96,8'h45,8'hfc,8'h41,8'h12,8'h0d,8'h79,8'he5,8'h89,8'h8c,8'he3,8'h20,
        8'h30,8'hdc,8'hb7,8'h6c,8'h4a,8'hb5,8'h3f,8'h97,8'hd4,8'h62,8'h2d,8'h06,8'ha4,8'ha5,8'h83,8'h5f,
        8'h2a,8'hda,8'hc9,8'h00,8'h7e,8'ha2,8'h55,8'hbf,8'h11,8'hd5,8'h9c,8'hcf,8'h0e,8'h0a,8'h3d,8'h51,
        8'h7d,8'h93,8'h1b,8'hfe,8'hc4,8'h47,8'h09,8'h86,8'h0b,8'h8f,8'h9d,8'h6a,8'h07,8'hb9,8'hb0,8'h98,
        8'h18,8'h32,8'h71,8'h4b,8'hef,8'h3b,8'h70,8'ha0,8'he4,8'h40,8'hff,8'hc3,8'ha9,8'he6,8'h78,8'hf9,
        8'h8b,8'h46,8'h80,8'h1e,8'h38,8'he1,8'hb8,8'ha8,8'he0,8'h0c,8'h23,8'h76,8'h1d,8'h25,8'h24,8'h05,
        8'hf1,8'h6e,8'h94,8'h28,8'h9a,8'h84,8'he8,8'ha3,8'h4f,8'h77,8'hd3,8'h85,8'he2,8'h52,8'hf2,8'h82,
        8'h50,8'h7a,8'h2f,8'h74,8'h53,8'hb3,8'h61,8'haf,8'h39,8'h35,8'hde,8'hcd,8'h1f,8'h99,8'hac,8'had,
        8'h72,8'h2c,8'hdd,8'hd0,8'h87,8'hbe,8'h5e,8'ha6,8'hec,8'h04,8'hc6,8'h03,8'h34,8'hfb,8'hdb,8'h59,
        8'hb6,8'hc2,8'h01,8'hf0,8'h5a,8'hed,8'ha7,8'h66,8'h21,8'h7f,8'h8a,8'h27,8'hc7,8'hc0,8'h29,8'hd7
        },
        '{
        8'h93,8'hd9,8'h9a,8'hb5,8'h98,8'h22,8'h45,8'hfc,8'hba,8'h6a,8'hdf,8'h02,8'h9f,8'hdc,8'h51,8'h59,
        8'h4a,8'h17,8'h2b,8'hc2,8'h94,8'hf4,8'hbb,8'ha3,8'h62,8'he4,8'h71,8'hd4,8'hcd,8'h70,8'h16,8'he1,
        8'h49,8'h3c,8'hc0,8'hd8,8'h5c,8'h9b,8'had,8'h85,8'h53,8'ha1,8'h7a,8'hc8,8'h2d,8'he0,8'hd1,8'h72,
        8'ha6,8'h2c,8'hc4,8'he3,8'h76,8'h78,8'hb7,8'hb4,8'h09,8'h3b,8'h0e,8'h41,8'h4c,8'hde,8'hb2,8'h90,
        8'h25,8'ha5,8'hd7,8'h03,8'h11,8'h00,8'hc3,8'h2e,8'h92,8'hef,8'h4e,8'h12,8'h9d,8'h7d,8'hcb,8'h35,
        8'h10,8'hd5,8'h4f,8'h9e,8'h4d,8'ha9,8'h55,8'hc6,8'hd0,8'h7b,8'h18,8'h97,8'hd3,8'h36,8'he6,8'h48,
        8'h56,8'h81,8'h8f,8'h77,8'hcc,8'h9c,8'hb9,8'he2,8'hac,8'hb8,8'h2f,8'h15,8'ha4,8'h7c,8'hda,8'h38,
        8'h1e,8'h0b,8'h05,8'hd6,8'h14,8'h6e,8'h6c,8'h7e,8'h66,8'hfd,8'hb1,8'he5,8'h60,8'haf,8'h5e,8'h33,
        8'h87,8'hc9,8'hf0,8'h5d,8'h6d,8'h3f,8'h88,8'h8d,8'hc7,8'hf7,8'h1d,8'he9,8'hec,8'hed,8'h80,8'h29,
        8'h27,8'hcf,8'h99,8'ha8,8'h50,8'h0f,8'h37,8'h24,8'h28,8'h30,8'h95,8'hd2,8'h3e,8'h5b,8'h40,8'h83,
        8'hb3,8'h69,8'h57,8'h1f,8'h07,8'h1c,8'h8a,8'hbc,8'h20,8'heb,8'hce,8'h8e,8'hab,8'hee,8'h31,8'ha2,
        8'h73,8'hf9,8'hca,8'h3a,8'h1a,8'hfb,8'h0d,8'hc1,8'hfe,8'hfa,8'hf2,8'h6f,8'hbd,8'h96,8'hdd,8'h43,
        8'h52,8'hb6,8'h08,8'hf3,8'hae,8'hbe,8'h19,8'h89,8'h32,8'h26,8'hb0,8'hea,8'h4b,8'h64,8'h84,8'h82,
        8'h6b,8'hf5,8'h79,8'hbf,8'h01,8'h5f,8'h75,8'h63,8'h1b,8'h23,8'h3d,8'h68,8'h2a,8'h65,8'he8,8'h91,
        8'hf6,8'hff,8'h13,8'h58,8'hf1,8'h47,8'h0a,8'h7f,8'hc5,8'ha7,8'he7,8'h61,8'h5a,8'h06,8'h46,8'h44,
        8'h42,8'h04,8'ha0,8'hdb,8'h39,8'h86,8'h54,8'haa,8'h8c,8'h34,8'h21,8'h8b,8'hf8,8'h0c,8'h74,8'h67
        },
        '{
        8'h68,8'h8d,8'hca,8'h4d,8'h73,8'h4b,8'h4e,8'h2a,8'hd4,8'h52,8'h26,8'hb3,8'h54,8'h1e,8'h19,8'h1f,
        8'h22,8'h03,8'h46,8'h3d,8'h2d,8'h4a,8'h53,8'h83,8'h13,8'h8a,8'hb7,8'hd5,8'h25,8'h79,8'hf5,8'hbd,
        8'h58,8'h2f,8'h0d,8'h02,8'hed,8'h51,8'h9e,8'h11,8'hf2,8'h3e,8'h55,8'h5e,8'hd1,8'h16,8'h3c,8'h66,
        8'h70,8'h5d,8'hf3,8'h45,8'h40,8'hcc,8'he8,8'h94,8'h56,8'h08,8'hce,8'h1a,8'h3a,8'hd2,8'he1,8'hdf,
        8'hb5,8'h38,8'h6e,8'h0e,8'he5,8'hf4,8'hf9,8'h86,8'he9,8'h4f,8'hd6,8'h85,8'h23,8'hcf,8'h32,8'h99,
        8'h31,8'h14,8'hae,8'hee,8'hc8,8'h48,8'hd3,8'h30,8'ha1,8'h92,8'h41,8'hb1,8'h18,8'hc4,8'h2c,8'h71,
        8'h72,8'h44,8'h15,8'hfd,8'h37,8'hbe,8'h5f,8'haa,8'h9b,8'h88,8'hd8,8'hab,8'h89,8'h9c,8'hfa,8'h60,
        8'hea,8'hbc,8'h62,8'h0c,8'h24,8'ha6,8'ha8,8'hec,8'h67,8'h20,8'hdb,8'h7c,8'h28,8'hdd,8'hac,8'h5b,
        8'h34,8'h7e,8'h10,8'hf1,8'h7b,8'h8f,8'h63,8'ha0,8'h05,8'h9a,8'h43,8'h77,8'h21,8'hbf,8'h27,8'h09,
        8'hc3,8'h9f,8'hb6,8'hd7,8'h29,8'hc2,8'heb,8'hc0,8'ha4,8'h8b,8'h8c,8'h1d,8'hfb,8'hff,8'hc1,8'hb2,
        8'h97,8'h2e,8'hf8,8'h65,8'hf6,8'h75,8'h07,8'h04,8'h49,8'h33,8'he4,8'hd9,8'hb9,8'hd0,8'h42,8'hc7,
        8'h6c,8'h90,8'h00,8'h8e,8'h6f,8'h50,8'h01,8'hc5,8'hda,8'h47,8'h3f,8'hcd,8'h69,8'ha2,8'he2,8'h7a,
        8'ha7,8'hc6,8'h93,8'h0f,8'h0a,8'h06,8'he6,8'h2b,8'h96,8'ha3,8'h1c,8'haf,8'h6a,8'h12,8'h84,8'h39,
        8'he7,8'hb0,8'h82,8'hf7,8'hfe,8'h9d,8'h87,8'h5c,8'h81,8'h35,8'hde,8'hb4,8'ha5,8'hfc,8'h80,8'hef,
        8'hcb,8'hbb,8'h6b,8'h76,8'hba,8'h5a,8'h7d,8'h78,8'h0b,8'h95,8'he3,8'had,8'h74,8'h98,8'h3b,8'h36,
        8'h64,8'h6d,8'hdc,8'hf0,8'h59,8'ha9,8'h4c,8'h17,8'h7f,8'h91,8'hb8,8'hc9,8'h57,8'h1b,8'he0,8'h61
        }
    };

    // Multiplication in GF(2^8) modulo x^8+x^4+x^3+x^2+1 by a small constant.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] f);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 4; i++)
        begin
            if (f[i])
            begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1D : 8'h00);
        end
        return acc;
    endfunction

endpackage

[rtl/core/kup_round.sv]
module kup_round (
    input  kup_pkg::blk_t       state_in,
    input  kup_pkg::round_ctl_t ctl,
    output kup_pkg::blk_t       state_out
);

    kup_pkg::blk_t added;
    kup_pkg::blk_t shifted;

    // Round constant: XOR into byte 0 of each column for P, addition per column for Q.
    always_comb
    begin
        logic [7:0]  k8;
        logic [63:0] cst;
        added = '0;
        k8    = 8'h00;
        cst   = 64'd0;
        for (int j = 0; j < 16; j++)
        begin
            if (ctl.q_mode)
            begin
                k8  = {4'(15 - j), 4'b0000} ^ {4'b0000, ctl.rnd};
                cst = kup_pkg::AddConst ^ {k8, 56'd0};
                added[64*j +: 64] = state_in[64*j +: 64] + cst;
            end
            else
            begin
                k8  = {4'(j), 4'b0000} ^ {4'b0000, ctl.rnd};
                added[64*j +: 64] = state_in[64*j +: 64] ^ {56'd0, k8};
            end
        end
    end

    // Substitution and row shift; row seven moves by eleven columns.
    always_comb
    begin
        logic [3:0] src;
        shifted = '0;
        for (int c = 0; c < 16; c++)
        begin
            for (int r = 0; r < 8; r++)
            begin
                src = (r == 7) ? 4'(c + 16 - 11) : 4'(c + 16 - r);
                shifted[64*c + 8*r +: 8] = kup_pkg::KSB[r % 4][added[64*src + 8*r +: 8]];
            end
        end
    end

    always_comb
    begin
        logic [7:0] acc;
        state_out = '0;
        for (int c = 0; c < 16; c++)
        begin
            for (int r = 0; r < 8; r++)
            begin
                acc = 8'h00;
                for (int k = 0; k < 8; k++)
                begin
                    acc = acc ^ kup_pkg::gf_mul(shifted[64*c + 8*k +: 8],
                                                kup_pkg::MDS_ROW[(k + 8 - r) % 8]);
                end
                state_out[64*c + 8*r +: 8] = acc;
            end
        end
    end

endmodule

[rtl/core/kupyna512_hash_engine.sv]
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  data_word, byte_count, last_word
// output    out        out_valid / out_stall digest_byte, digest_end
// config    in         cfg_we               cfg_data (digest_bytes)
//
// A word is accepted while idle, then loaded into the block buffer byte by byte.
// A block runs on the shared round unit: load, 14 P and 14 Q rounds, fold.
// Finalising takes a pad and a fill step, up to two blocks, then the output
// transform (set-up, 14 P rounds, fold), then one digest byte per beat.
// Reset is asynchronous; the digest size comes back as 64 and the chaining value as the
// initial value. A stalled output beat holds until taken; in_stall is high while busy.
module kupyna512_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  digest_byte,
    output logic        digest_end,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data
);

    kup_pkg::fsm_t state_reg, state_next;
    kup_pkg::fsm_t after_reg, after_next;

    kup_pkg::blk_t chain_reg, chain_next;
    kup_pkg::blk_t buf_reg, buf_next;
    kup_pkg::blk_t p_reg, p_next;
    kup_pkg::blk_t q_reg, q_next;
    kup_pkg::blk_t round_out;
    kup_pkg::round_ctl_t ctl;

    logic [6:0]  pos_reg, pos_next;
    logic [63:0] bits_reg, bits_next;
    logic [63:0] word_reg, word_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [3:0]  idx_reg, idx_next;
    logic [3:0]  rnd_reg, rnd_next;
    logic        phase_reg, phase_next;
    logic        final_reg, final_next;
    logic [6:0]  oidx_reg, oidx_next;
    logic [6:0]  dig_reg;

    logic        in_take;
    logic        out_take;
    logic [3:0]  cnt_clip;
    logic [6:0]  n_out;
    logic        round_done;

    kup_pkg::blk_t init_chain;

    assign init_chain = {{960{1'b0}}, 64'd128};
    assign in_stall   = (state_reg != kup_pkg::ST_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign out_valid  = (state_reg == kup_pkg::ST_EMIT);
    assign out_take   = out_valid && !out_stall;
    assign digest_byte = chain_reg[{oidx_reg, 3'b000} +: 8];
    assign digest_end  = (oidx_reg == kup_pkg::LastByte);
    assign cnt_clip   = (byte_count > 4'd8) ? 4'd8 : byte_count;
    assign n_out      = (dig_reg > kup_pkg::MaxDigest) ? kup_pkg::MaxDigest : dig_reg;
    assign round_done = (rnd_reg == kup_pkg::LastRound) && (phase_reg || final_reg);

    assign ctl.q_mode = phase_reg;
    assign ctl.rnd    = rnd_reg;

    kup_round u_round (
        .state_in  (phase_reg ? q_reg : p_reg),
        .ctl       (ctl),
        .state_out (round_out)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kup_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = kup_pkg::ST_LOAD;
                end
            end
            kup_pkg::ST_LOAD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    state_next = last_reg ? kup_pkg::ST_PAD : kup_pkg::ST_IDLE;
                end
                else if (pos_reg == kup_pkg::LastByte)
                begin
                    state_next = kup_pkg::ST_INIT;
                end
            end
            kup_pkg::ST_PAD:
            begin
                state_next = (pos_reg >= kup_pkg::LenAt) ? kup_pkg::ST_INIT : kup_pkg::ST_FILL;
            end
            kup_pkg::ST_FILL:  state_next = kup_pkg::ST_INIT;
            kup_pkg::ST_INIT:  state_next = kup_pkg::ST_ROUND;
            kup_pkg::ST_OINIT: state_next = kup_pkg::ST_ROUND;
            kup_pkg::ST_ROUND:
            begin
                if (round_done)
                begin
                    state_next = kup_pkg::ST_FOLD;
                end
            end
            kup_pkg::ST_FOLD:
            begin
                if (final_reg)
                begin
                    state_next = (n_out == 7'd0) ? kup_pkg::ST_IDLE : kup_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = after_reg;
                end
            end
            kup_pkg::ST_EMIT:
            begin
                if (out_take && digest_end)
                begin
                    state_next = kup_pkg::ST_IDLE;
                end
            end
            default: state_next = kup_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        chain_next = chain_reg;
        buf_next   = buf_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        pos_next   = pos_reg;
        bits_next  = bits_reg;
        word_next  = word_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        rnd_next   = rnd_reg;
        phase_next = phase_reg;
        final_next = final_reg;
        oidx_next  = oidx_reg;
        after_next = after_reg;
        unique case (state_reg)
            kup_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    word_next = data_word;
                    cnt_next  = cnt_clip;
                    last_next = last_word;
                    idx_next  = 4'd0;
                    bits_next = bits_reg + 64'({cnt_clip, 3'b000});
                end
            end
            kup_pkg::ST_LOAD:
            begin
                if (idx_reg != cnt_reg)
                begin
                    buf_next[{pos_reg, 3'b000} +: 8] = word_reg[{idx_reg[2:0], 3'b000} +: 8];
                    pos_next   = pos_reg + 7'd1;
                    idx_next   = idx_reg + 4'd1;
                    after_next = kup_pkg::ST_LOAD;
                end
            end
            kup_pkg::ST_PAD:
            begin
                buf_next[{pos_reg, 3'b000} +: 8] = kup_pkg::PadByte;
                if (pos_reg >= kup_pkg::LenAt)
                begin
                    // Length no longer fits: close this block with zeros first.
                    for (int b = 0; b < 128; b++)
                    begin
                        if (7'(b) > pos_reg)
                        begin
                            buf_next[8*b +: 8] = 8'h00;
                        end
                    end
                    pos_next   = 7'd0;
                    after_next = kup_pkg::ST_FILL;
                end
                else
                begin
                    pos_next = pos_reg + 7'd1;
                end
            end
            kup_pkg::ST_FILL:
            begin
                for (int b = 0; b < 128; b++)
                begin
                    if (7'(b) >= pos_reg)
                    begin
                        buf_next[8*b +: 8] = 8'h00;
                    end
                end
                buf_next[64*14 + 32 +: 32] = bits_reg[31:0];
                buf_next[64*15 +: 64]      = {32'd0, bits_reg[63:32]};
                after_next = kup_pkg::ST_OINIT;
            end
            kup_pkg::ST_INIT:
            begin
                p_next     = chain_reg ^ buf_reg;
                q_next     = buf_reg;
                rnd_next   = 4'd0;
                phase_next = 1'b0;
                final_next = 1'b0;
            end
            kup_pkg::ST_OINIT:
            begin
                p_next     = chain_reg;
                rnd_next   = 4'd0;
                phase_next = 1'b0;
                final_next = 1'b1;
            end
            kup_pkg::ST_ROUND:
            begin
                if (phase_reg)
                begin
                    q_next     = round_out;
                    phase_next = 1'b0;
                    rnd_next   = rnd_reg + 4'd1;
                end
                else
                begin
                    p_next = round_out;
                    if (final_reg)
                    begin
                        rnd_next = rnd_reg + 4'd1;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                    end
                end
            end
            kup_pkg::ST_FOLD:
            begin
                if (final_reg)
                begin
                    chain_next = chain_reg ^ p_reg;
                    oidx_next  = 7'(8'd128 - {1'b0, n_out});
                    if (n_out == 7'd0)
                    begin
                        chain_next = init_chain;
                        pos_next   = 7'd0;
                        bits_next  = 64'd0;
                    end
                end
                else
                begin
                    chain_next = chain_reg ^ p_reg ^ q_reg;
                end
            end
            kup_pkg::ST_EMIT:
            begin
                if (out_take)
                begin
                    oidx_next = oidx_reg + 7'd1;
                    if (digest_end)
                    begin
                        chain_next = init_chain;
                        pos_next   = 7'd0;
                        bits_next  = 64'd0;
                    end
                end
            end
            default:
            begin
                chain_next = chain_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kup_pkg::ST_IDLE;
            after_reg <= kup_pkg::ST_LOAD;
            chain_reg <= init_chain;
            pos_reg   <= 7'd0;
            bits_reg  <= 64'd0;
            idx_reg   <= 4'd0;
            cnt_reg   <= 4'd0;
            last_reg  <= 1'b0;
            rnd_reg   <= 4'd0;
            phase_reg <= 1'b0;
            final_reg <= 1'b0;
            oidx_reg  <= 7'd0;
            dig_reg   <= kup_pkg::MaxDigest;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            chain_reg <= chain_next;
            pos_reg   <= pos_next;
            bits_reg  <= bits_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            rnd_reg   <= rnd_next;
            phase_reg <= phase_next;
            final_reg <= final_next;
            oidx_reg  <= oidx_next;
            if (cfg_we)
            begin
                dig_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        word_reg <= word_next;
    end

endmodule
